// File: sv/ppa_pkg.sv
// shared constants, codes and types of the page pool allocator
`timescale 1ns / 1ps
`default_nettype none

package ppa_pkg;

   localparam int POOL_PAGES = 256;
   localparam int PAGE_BYTES = 4096;
   localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
   localparam int SLOT_AW    = $clog2(POOL_PAGES);
   localparam int SLOT_W     = $clog2(POOL_PAGES + 1);
   localparam int LINK_W     = 1 + SLOT_W;
   localparam int ADDR_W     = 64;
   localparam int CNT_W      = 9;
   localparam int STATUS_W   = 3;
   localparam int FUNC_W     = 2;

   typedef logic [SLOT_W-1:0] slot_type;

   localparam slot_type NULL_SLOT = SLOT_W'(POOL_PAGES);

   typedef enum logic [FUNC_W-1:0] {
      FN_INIT    = 2'd0,
      FN_ALLOC   = 2'd1,
      FN_RELEASE = 2'd2
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK         = 3'd0,
      ST_NOT_READY  = 3'd1,
      ST_NO_FREE    = 3'd2,
      ST_BAD_TARGET = 3'd3,
      ST_BAD_SIZE   = 3'd4
   } status_type;

   typedef struct packed {
      logic     used;
      slot_type next;
   } link_type;

   typedef struct packed {
      logic               below;
      logic               beyond;
      logic [SLOT_AW-1:0] index;
      logic [ADDR_W-1:0]  granted;
   } addr_info_type;

   function automatic logic is_slot(slot_type s);
      return s < NULL_SLOT;
   endfunction

endpackage

`default_nettype wire

// File: sv/ppa_if.sv
// request, response and register write channels of the page pool allocator
`timescale 1ns / 1ps
`default_nettype none

interface ppa_req_if import ppa_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [FUNC_W-1:0] func;
   logic [ADDR_W-1:0] page_address;
   logic [ADDR_W-1:0] requested_pages;

   modport source (output valid, func, page_address, requested_pages, input ready);
   modport sink   (input valid, func, page_address, requested_pages, output ready);
endinterface

interface ppa_rsp_if import ppa_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [ADDR_W-1:0]   granted_address;
   logic [CNT_W-1:0]    pages_in_use;

   modport source (output valid, status, granted_address, pages_in_use, input ready);
   modport sink   (input valid, status, granted_address, pages_in_use, output ready);
endinterface

interface ppa_csr_if import ppa_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [ADDR_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// File: sv/ppa_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module ppa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// File: sv/ppa_addr.sv
// release address decode and granted address generation
`timescale 1ns / 1ps
`default_nettype none

module ppa_addr import ppa_pkg::*; (
   input  logic [ADDR_W-1:0]  pool_base,
   input  logic [ADDR_W-1:0]  release_address,
   input  logic [SLOT_AW-1:0] grant_slot,
   output addr_info_type      addr_info
);

   logic [ADDR_W-1:0] offset;
   logic [ADDR_W-1:0] page_no;

   always_comb begin
      offset              = release_address - pool_base;
      page_no             = offset >> PAGE_SHIFT;
      addr_info.below     = release_address < pool_base;
      addr_info.beyond    = page_no >= ADDR_W'(POOL_PAGES);
      addr_info.index     = page_no[SLOT_AW-1:0];
      addr_info.granted   = pool_base + (ADDR_W'(grant_slot) << PAGE_SHIFT);
   end

endmodule

`default_nettype wire

// File: sv/ppa_ctrl.sv
// list sequencer with the link memories of the page pool allocator
`timescale 1ns / 1ps
`default_nettype none

module ppa_ctrl import ppa_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   ppa_req_if.sink            req_bus,
   ppa_rsp_if.source          rsp_bus,
   input  addr_info_type      addr_info,
   output logic [ADDR_W-1:0]  release_address,
   output logic [SLOT_AW-1:0] grant_slot
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_ADDR,
      S_AL_W1,
      S_AL_W2,
      S_RL_W1,
      S_RL_W2,
      S_RL_W3,
      S_INIT,
      S_DONE
   } state_type;

   state_type           state_ff;
   slot_type            free_head_ff;
   slot_type            used_head_ff;
   logic [CNT_W-1:0]    count_ff;
   logic                pool_ready_ff;
   logic [SLOT_AW-1:0]  slot_ff;
   logic [SLOT_AW-1:0]  init_ff;
   slot_type            prev_ff;
   slot_type            next_ff;
   logic [ADDR_W-1:0]   address_ff;
   status_type          res_status_ff;
   logic [ADDR_W-1:0]   res_granted_ff;
   logic                rsp_valid_ff;
   status_type          rsp_status_ff;
   logic [ADDR_W-1:0]   rsp_granted_ff;
   logic [CNT_W-1:0]    rsp_count_ff;

   logic                rd_en;
   logic [SLOT_AW-1:0]  rd_addr;
   logic                link_we;
   logic [SLOT_AW-1:0]  link_wa;
   link_type            link_wd;
   logic [LINK_W-1:0]   link_rd_data;
   link_type            link_rd;
   logic                prev_we;
   logic [SLOT_AW-1:0]  prev_wa;
   slot_type            prev_wd;
   slot_type            prev_rd;

   ppa_ram #(.WIDTH(LINK_W), .DEPTH(POOL_PAGES)) u_link_ram (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (link_wa),
      .wr_data (link_wd),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (link_rd_data)
   );

   ppa_ram #(.WIDTH(SLOT_W), .DEPTH(POOL_PAGES)) u_prev_ram (
      .clock   (clock),
      .wr_en   (prev_we),
      .wr_addr (prev_wa),
      .wr_data (prev_wd),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (prev_rd)
   );

   assign link_rd         = link_type'(link_rd_data);
   assign release_address = address_ff;
   assign grant_slot      = slot_ff;

   assign req_bus.ready   = (state_ff == S_IDLE);
   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.status  = rsp_status_ff;
   assign rsp_bus.granted_address = rsp_granted_ff;
   assign rsp_bus.pages_in_use    = rsp_count_ff;

   always_comb begin
      rd_en   = 1'b0;
      rd_addr = free_head_ff[SLOT_AW-1:0];
      link_we = 1'b0;
      link_wa = slot_ff;
      link_wd = '{used: 1'b0, next: NULL_SLOT};
      prev_we = 1'b0;
      prev_wa = slot_ff;
      prev_wd = NULL_SLOT;
      unique case (state_ff)
         S_IDLE: begin
            rd_en   = 1'b1;
            rd_addr = free_head_ff[SLOT_AW-1:0];
         end
         S_ADDR: begin
            rd_en   = 1'b1;
            rd_addr = addr_info.index;
         end
         S_AL_W1: begin
            link_we = 1'b1;
            link_wd = '{used: 1'b1, next: used_head_ff};
            prev_we = is_slot(link_rd.next);
            prev_wa = link_rd.next[SLOT_AW-1:0];
            prev_wd = NULL_SLOT;
         end
         S_AL_W2: begin
            prev_we = is_slot(used_head_ff);
            prev_wa = used_head_ff[SLOT_AW-1:0];
            prev_wd = SLOT_W'(slot_ff);
         end
         S_RL_W1: begin
            link_we = link_rd.used;
            link_wd = '{used: 1'b0, next: free_head_ff};
            prev_we = link_rd.used && is_slot(link_rd.next);
            prev_wa = link_rd.next[SLOT_AW-1:0];
            prev_wd = prev_rd;
         end
         S_RL_W2: begin
            link_we = is_slot(prev_ff);
            link_wa = prev_ff[SLOT_AW-1:0];
            link_wd = '{used: 1'b1, next: next_ff};
            prev_we = is_slot(free_head_ff);
            prev_wa = free_head_ff[SLOT_AW-1:0];
            prev_wd = SLOT_W'(slot_ff);
         end
         S_RL_W3: begin
            prev_we = 1'b1;
            prev_wd = NULL_SLOT;
         end
         S_INIT: begin
            link_we = 1'b1;
            link_wa = init_ff;
            link_wd.used = 1'b0;
            link_wd.next = (init_ff == SLOT_AW'(POOL_PAGES - 1)) ? NULL_SLOT
                                                                  : SLOT_W'(init_ff) + 1'b1;
            prev_we = 1'b1;
            prev_wa = init_ff;
            prev_wd = (init_ff == '0) ? NULL_SLOT : SLOT_W'(init_ff) - 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         free_head_ff  <= NULL_SLOT;
         used_head_ff  <= NULL_SLOT;
         count_ff      <= '0;
         pool_ready_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (rsp_bus.ready && state_ff != S_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_bus.valid) begin
                  address_ff     <= req_bus.page_address;
                  res_granted_ff <= '0;
                  unique case (func_type'(req_bus.func))
                     FN_INIT: begin
                        if (req_bus.requested_pages != ADDR_W'(POOL_PAGES)) begin
                           res_status_ff <= ST_BAD_SIZE;
                           state_ff      <= S_DONE;
                        end else begin
                           init_ff  <= '0;
                           state_ff <= S_INIT;
                        end
                     end
                     FN_ALLOC: begin
                        if (!pool_ready_ff) begin
                           res_status_ff <= ST_NOT_READY;
                           state_ff      <= S_DONE;
                        end else if (!is_slot(free_head_ff)) begin
                           res_status_ff <= ST_NO_FREE;
                           state_ff      <= S_DONE;
                        end else begin
                           slot_ff  <= free_head_ff[SLOT_AW-1:0];
                           state_ff <= S_AL_W1;
                        end
                     end
                     FN_RELEASE: begin
                        if (!pool_ready_ff) begin
                           res_status_ff <= ST_NOT_READY;
                           state_ff      <= S_DONE;
                        end else begin
                           state_ff <= S_ADDR;
                        end
                     end
                     default: begin
                        res_status_ff <= ST_BAD_TARGET;
                        state_ff      <= S_DONE;
                     end
                  endcase
               end
            end
            S_ADDR: begin
               if (addr_info.below || addr_info.beyond) begin
                  res_status_ff <= ST_BAD_TARGET;
                  state_ff      <= S_DONE;
               end else begin
                  slot_ff  <= addr_info.index;
                  state_ff <= S_RL_W1;
               end
            end
            S_AL_W1: begin
               free_head_ff <= link_rd.next;
               state_ff     <= S_AL_W2;
            end
            S_AL_W2: begin
               used_head_ff   <= SLOT_W'(slot_ff);
               count_ff       <= count_ff + 1'b1;
               res_status_ff  <= ST_OK;
               res_granted_ff <= addr_info.granted;
               state_ff       <= S_DONE;
            end
            S_RL_W1: begin
               if (!link_rd.used) begin
                  res_status_ff <= ST_BAD_TARGET;
                  state_ff      <= S_DONE;
               end else begin
                  prev_ff  <= prev_rd;
                  next_ff  <= link_rd.next;
                  state_ff <= S_RL_W2;
               end
            end
            S_RL_W2: begin
               state_ff <= S_RL_W3;
            end
            S_RL_W3: begin
               if (!is_slot(prev_ff)) begin
                  used_head_ff <= next_ff;
               end
               free_head_ff <= SLOT_W'(slot_ff);
               if (count_ff != '0) begin
                  count_ff <= count_ff - 1'b1;
               end
               res_status_ff <= ST_OK;
               state_ff      <= S_DONE;
            end
            S_INIT: begin
               init_ff <= init_ff + 1'b1;
               if (init_ff == SLOT_AW'(POOL_PAGES - 1)) begin
                  free_head_ff  <= '0;
                  used_head_ff  <= NULL_SLOT;
                  count_ff      <= '0;
                  pool_ready_ff <= 1'b1;
                  res_status_ff <= ST_OK;
                  state_ff      <= S_DONE;
               end
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp_bus.ready) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_status_ff  <= res_status_ff;
                  rsp_granted_ff <= res_granted_ff;
                  rsp_count_ff   <= count_ff;
                  state_ff       <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

// File: sv/page_pool_allocator.sv
// Page pool allocator: keeps a pool of 256 pages of 4 KiB starting at the address
// in the pool_base register, chained into a free list and a used list through two
// link memories (used mark with next link, and previous link), one write port each.
// Items are handled one at a time, and the next request beat is taken once the
// result of the current one sits in the response register. An item can be rejected
// at once (wrong pool size, not initialized, no free page, unknown operation), a
// release can be rejected on its address, and a release of a free slot is rejected
// after its link read. While the response register stays full on a stalled receiver,
// the next request is not taken. Init writes every slot of the link memories once,
// and allocate and release are bound by the dependent link reads and writes on the
// single memory ports.
// The register write channel is always ready; write it only while idle.
`timescale 1ns / 1ps
`default_nettype none

module page_pool_allocator import ppa_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   ppa_req_if.sink   req_bus,
   ppa_rsp_if.source rsp_bus,
   ppa_csr_if.sink   csr_bus
);

   logic [ADDR_W-1:0]  pool_base_ff;
   logic [ADDR_W-1:0]  release_address;
   logic [SLOT_AW-1:0] grant_slot;
   addr_info_type      addr_info;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_base_ff <= '0;
      end else if (csr_bus.valid) begin
         pool_base_ff <= csr_bus.data;
      end
   end

   ppa_addr u_addr (
      .pool_base       (pool_base_ff),
      .release_address (release_address),
      .grant_slot      (grant_slot),
      .addr_info       (addr_info)
   );

   ppa_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_bus         (req_bus),
      .rsp_bus         (rsp_bus),
      .addr_info       (addr_info),
      .release_address (release_address),
      .grant_slot      (grant_slot)
   );

endmodule

`default_nettype wire

// File: sv/ppa_checker.sv
// port checker of the page pool allocator and its bind
`timescale 1ns / 1ps
`default_nettype none

module ppa_checker import ppa_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [STATUS_W-1:0] rsp_status,
   input logic [ADDR_W-1:0]   rsp_granted,
   input logic [CNT_W-1:0]    rsp_pages
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_granted))
      else $error("response beat dropped or changed while stalled");

   a_grant_only_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_granted == '0)
      else $error("granted address on a failed item");

   a_pages_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_pages <= CNT_W'(POOL_PAGES))
      else $error("pages in use beyond pool size");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while an item is in work");

endmodule

bind page_pool_allocator ppa_checker u_ppa_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_bus.valid),
   .req_ready   (req_bus.ready),
   .rsp_valid   (rsp_bus.valid),
   .rsp_ready   (rsp_bus.ready),
   .rsp_status  (rsp_bus.status),
   .rsp_granted (rsp_bus.granted_address),
   .rsp_pages   (rsp_bus.pages_in_use)
);

`default_nettype wire
